### design/sncp_pkg.sv
// Shared widths, register indexes, side-band types and helpers for the
// segment near-clip projection pipeline. No dependencies.
package sncp_pkg;

    // camera-space coordinate width (Q.16, signed)
    localparam int VW       = 29;
    // clip difference / numerator width, and clip divider quotient width
    localparam int DXW      = VW + 1;
    localparam int HALF     = DXW / 2;
    localparam int CNW      = 2 * DXW;
    localparam int CLIP_QW  = DXW;
    // projection product width and projection quotient width
    localparam int PW       = VW + 17;
    localparam int PROJ_QW  = 17;
    localparam int NPROJ    = 4;
    // total register stages from input to output
    localparam int LAT      = 6 + CLIP_QW + 3 + PROJ_QW + 1;

    localparam logic [2:0] CFG_EYE     = 3'd0;
    localparam logic [2:0] CFG_RIGHT   = 3'd1;
    localparam logic [2:0] CFG_UP      = 3'd2;
    localparam logic [2:0] CFG_FORWARD = 3'd3;
    localparam logic [2:0] CFG_FOCAL   = 3'd4;
    localparam logic [2:0] CFG_CX      = 3'd5;
    localparam logic [2:0] CFG_CY      = 3'd6;
    localparam logic [2:0] CFG_NEAR    = 3'd7;

    localparam logic [14:0] NEAR_RESET = 15'd13;

    typedef struct packed {
        logic                 vis;
        logic                 clip;
        logic                 swap;
        logic signed [VW-1:0] mx;
        logic signed [VW-1:0] my;
        logic signed [VW-1:0] mz;
        logic signed [VW-1:0] ox;
        logic signed [VW-1:0] oy;
        logic signed [VW-1:0] oz;
    } t_clip_side;

    typedef struct packed {
        logic             vis;
        logic [NPROJ-1:0] ovf;
        logic [NPROJ-1:0] neg;
    } t_proj_side;

    function automatic logic [15:0] sat16(input logic signed [18:0] x);
        logic [15:0] r;
        if (x > 19'sd32767) r = 16'h7fff;
        else if (x < -19'sd32768) r = 16'h8000;
        else r = x[15:0];
        return r;
    endfunction

endpackage

### design/sncp_div.sv
// Pipelined restoring divider: one quotient bit per stage, unsigned
// magnitudes in, signed truncated quotient out. No package dependency.
module sncp_div #(
    parameter int DW = 30,
    parameter int QW = 30,
    localparam int NW = DW + QW
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [NW-1:0]     i_num,   // must be below den * 2^QW
    input  logic [DW-1:0]     i_den,
    input  logic              i_neg,
    output logic signed [QW:0] o_quo
);

    logic [NW-1:0] w_rem [QW];
    logic [DW-1:0] w_den [QW];
    logic [QW-1:0] w_q   [QW];
    logic          w_neg [QW];

    logic [NW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_q   [QW];
    logic          r_neg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [NW-1:0] trial;
        logic [NW-1:0] n_rem;
        logic [QW-1:0] n_q;

        if (k == 0) begin : g_first
            assign w_rem[k] = i_num;
            assign w_den[k] = i_den;
            assign w_q[k]   = '0;
            assign w_neg[k] = i_neg;
        end else begin : g_next
            assign w_rem[k] = r_rem[k-1];
            assign w_den[k] = r_den[k-1];
            assign w_q[k]   = r_q[k-1];
            assign w_neg[k] = r_neg[k-1];
        end

        always_comb begin
            trial = NW'(w_den[k]) << (QW - 1 - k);
            if (w_rem[k] >= trial) begin
                n_rem = w_rem[k] - trial;
                n_q   = w_q[k] | (QW'(1) << (QW - 1 - k));
            end else begin
                n_rem = w_rem[k];
                n_q   = w_q[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_den[k] <= w_den[k];
                r_q[k]   <= n_q;
                r_neg[k] <= w_neg[k];
            end
        end
    end

    assign o_quo = r_neg[QW-1] ? -$signed({1'b0, r_q[QW-1]}) : $signed({1'b0, r_q[QW-1]});

endmodule

### design/segment_near_clip_project_top.sv
// Segment near-plane clip and perspective projection, fully pipelined.
// Register stages from input word to output word: 6 front stages,
// 30-stage clip divider, 3 stages, 17-stage projection divider, output reg.
// Throughput: one segment word per cycle; the whole pipe freezes only while
// the output register holds a word that is not taken.
// Reset (i_rst_n low, synchronous): pipe emptied, registers to their reset
// values (near distance 13, all others 0).
module segment_near_clip_project_top
    import sncp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [47:0]        i_cfg_data,
    // segment input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_start_x,
    input  logic signed [15:0] i_start_y,
    input  logic signed [15:0] i_start_z,
    input  logic signed [15:0] i_end_x,
    input  logic signed [15:0] i_end_y,
    input  logic signed [15:0] i_end_z,
    // result output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_visible,
    output logic signed [15:0] o_start_screen_x,
    output logic signed [15:0] o_start_screen_y,
    output logic signed [15:0] o_end_screen_x,
    output logic signed [15:0] o_end_screen_y
);

    // ---------------- configuration registers ----------------
    logic [47:0] r_eye, r_right, r_up, r_fwd;
    logic [15:0] r_focal, r_cx, r_cy;
    logic [14:0] r_near;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eye   <= '0;
            r_right <= '0;
            r_up    <= '0;
            r_fwd   <= '0;
            r_focal <= '0;
            r_cx    <= '0;
            r_cy    <= '0;
            r_near  <= NEAR_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_EYE:     r_eye   <= i_cfg_data;
                CFG_RIGHT:   r_right <= i_cfg_data;
                CFG_UP:      r_up    <= i_cfg_data;
                CFG_FORWARD: r_fwd   <= i_cfg_data;
                CFG_FOCAL:   r_focal <= i_cfg_data[15:0];
                CFG_CX:      r_cx    <= i_cfg_data[15:0];
                CFG_CY:      r_cy    <= i_cfg_data[15:0];
                CFG_NEAR:    r_near  <= i_cfg_data[14:0];
                default:     ;
            endcase
        end
    end

    // near depth in Q.16; config must only be rewritten while the pipe is empty
    // (the block does not enforce this), so every stage may read it directly
    logic signed [VW-1:0] w_nearq;
    assign w_nearq = VW'({r_near, 8'b0});

    // ---------------- pipe control ----------------
    // Global advance: every stage moves when the output register is free or
    // being drained. Valid bits shift alongside the data.
    logic           w_en;
    logic [LAT:1]   r_vld;

    assign w_en        = !r_vld[LAT] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-1:1], i_in_valid};
        end
    end

    // ---------------- S1: subtract eye ----------------
    logic signed [15:0] w_pt [6];
    logic signed [16:0] r1_d [6];

    assign w_pt[0] = i_start_x;
    assign w_pt[1] = i_start_y;
    assign w_pt[2] = i_start_z;
    assign w_pt[3] = i_end_x;
    assign w_pt[4] = i_end_y;
    assign w_pt[5] = i_end_z;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 6; i++) begin
                r1_d[i] <= 17'(w_pt[i]) - 17'($signed(r_eye[16*(i%3) +: 16]));
            end
        end
    end

    // ---------------- S2: axis products ----------------
    logic [47:0]        w_axis [3];
    logic signed [32:0] r2_p [2][3][3];   // endpoint, axis, component

    assign w_axis[0] = r_right;
    assign w_axis[1] = r_up;
    assign w_axis[2] = r_fwd;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int e = 0; e < 2; e++) begin
                for (int a = 0; a < 3; a++) begin
                    for (int k = 0; k < 3; k++) begin
                        r2_p[e][a][k] <= r1_d[e*3+k] * $signed(w_axis[a][16*k +: 16]);
                    end
                end
            end
        end
    end

    // ---------------- S3: dot sums, floor Q.22 -> Q.16 ----------------
    logic signed [VW-1:0] r3_v [2][3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int e = 0; e < 2; e++) begin
                for (int a = 0; a < 3; a++) begin
                    r3_v[e][a] <= VW'((35'(r2_p[e][a][0]) + 35'(r2_p[e][a][1])
                                     + 35'(r2_p[e][a][2])) >>> 6);
                end
            end
        end
    end

    // ---------------- S4: near test, pick moved endpoint ----------------
    logic                  w_a_beh, w_b_beh, w_swap;
    logic signed [VW-1:0]  w_m [3];
    logic signed [VW-1:0]  w_o [3];
    t_clip_side            r4_side;
    logic [DXW-1:0]        r4_num, r4_den;
    logic signed [DXW-1:0] r4_dx, r4_dy;

    always_comb begin
        w_a_beh = r3_v[0][2] <= w_nearq;
        w_b_beh = r3_v[1][2] <= w_nearq;
        w_swap  = w_b_beh && !w_a_beh;   // the end point gets moved
        for (int k = 0; k < 3; k++) begin
            w_m[k] = w_swap ? r3_v[1][k] : r3_v[0][k];
            w_o[k] = w_swap ? r3_v[0][k] : r3_v[1][k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_side.vis  <= !(w_a_beh && w_b_beh);
            r4_side.clip <= w_a_beh ^ w_b_beh;
            r4_side.swap <= w_swap;
            r4_side.mx   <= w_m[0];
            r4_side.my   <= w_m[1];
            r4_side.mz   <= w_m[2];
            r4_side.ox   <= w_o[0];
            r4_side.oy   <= w_o[1];
            r4_side.oz   <= w_o[2];
            r4_num <= DXW'(w_nearq) - DXW'(w_m[2]);
            r4_den <= DXW'(w_o[2]) - DXW'(w_m[2]);
            r4_dx  <= DXW'(w_o[0]) - DXW'(w_m[0]);
            r4_dy  <= DXW'(w_o[1]) - DXW'(w_m[1]);
        end
    end

    // ---------------- S5: |diff| * num, split in halves ----------------
    logic [DXW-1:0]      w_mag_x, w_mag_y;
    logic [DXW+HALF-1:0] r5_phx, r5_plx, r5_phy, r5_ply;
    logic [DXW-1:0]      r5_den;
    logic                r5_negx, r5_negy;
    t_clip_side          r5_side;

    assign w_mag_x = r4_dx[DXW-1] ? DXW'(-r4_dx) : DXW'(r4_dx);
    assign w_mag_y = r4_dy[DXW-1] ? DXW'(-r4_dy) : DXW'(r4_dy);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_phx  <= w_mag_x * r4_num[DXW-1:HALF];
            r5_plx  <= w_mag_x * r4_num[HALF-1:0];
            r5_phy  <= w_mag_y * r4_num[DXW-1:HALF];
            r5_ply  <= w_mag_y * r4_num[HALF-1:0];
            r5_den  <= r4_den;
            r5_negx <= r4_dx[DXW-1];
            r5_negy <= r4_dy[DXW-1];
            r5_side <= r4_side;
        end
    end

    // ---------------- S6: join partial products ----------------
    logic [CNW-1:0] r6_px, r6_py;
    logic [DXW-1:0] r6_den;
    logic           r6_negx, r6_negy;
    t_clip_side     r6_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_px   <= (CNW'(r5_phx) << HALF) + CNW'(r5_plx);
            r6_py   <= (CNW'(r5_phy) << HALF) + CNW'(r5_ply);
            r6_den  <= r5_den;
            r6_negx <= r5_negx;
            r6_negy <= r5_negy;
            r6_side <= r5_side;
        end
    end

    // ---------------- clip dividers (CLIP_QW stages) ----------------
    // Moved point lies between the endpoints, so |quotient| < |diff|.
    logic signed [CLIP_QW:0] w_qx, w_qy;
    t_clip_side              r_cside [CLIP_QW];

    sncp_div #(.DW(DXW), .QW(CLIP_QW)) u_div_cx (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r6_px),
        .i_den (r6_den),
        .i_neg (r6_negx),
        .o_quo (w_qx)
    );

    sncp_div #(.DW(DXW), .QW(CLIP_QW)) u_div_cy (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r6_py),
        .i_den (r6_den),
        .i_neg (r6_negy),
        .o_quo (w_qy)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cside[0] <= r6_side;
            for (int i = 1; i < CLIP_QW; i++) begin
                r_cside[i] <= r_cside[i-1];
            end
        end
    end

    // ---------------- S37: apply clip, restore endpoint order ----------------
    t_clip_side            w_cs;
    logic signed [CLIP_QW:0] w_sx, w_sy;
    logic signed [VW-1:0]  w_mm [3];
    logic signed [VW-1:0]  w_oo [3];
    logic signed [VW-1:0]  r37_a [3];
    logic signed [VW-1:0]  r37_b [3];
    logic                  r37_vis;

    always_comb begin
        w_cs  = r_cside[CLIP_QW-1];
        w_sx  = (CLIP_QW+1)'(w_cs.mx) + w_qx;
        w_sy  = (CLIP_QW+1)'(w_cs.my) + w_qy;
        w_mm[0] = w_cs.clip ? VW'(w_sx) : w_cs.mx;
        w_mm[1] = w_cs.clip ? VW'(w_sy) : w_cs.my;
        w_mm[2] = w_cs.clip ? w_nearq   : w_cs.mz;
        w_oo[0] = w_cs.ox;
        w_oo[1] = w_cs.oy;
        w_oo[2] = w_cs.oz;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r37_a[k] <= w_cs.swap ? w_oo[k] : w_mm[k];
                r37_b[k] <= w_cs.swap ? w_mm[k] : w_oo[k];
            end
            r37_vis <= w_cs.vis;
        end
    end

    // ---------------- S38: v * focal ----------------
    // lanes: 0 start x, 1 start y, 2 end x, 3 end y
    logic signed [VW-1:0] w_lane [NPROJ];
    logic signed [PW-1:0] r38_p [NPROJ];
    logic signed [VW-1:0] r38_az, r38_bz;
    logic                 r38_vis;

    assign w_lane[0] = r37_a[0];
    assign w_lane[1] = r37_a[1];
    assign w_lane[2] = r37_b[0];
    assign w_lane[3] = r37_b[1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < NPROJ; i++) begin
                r38_p[i] <= PW'(w_lane[i]) * PW'($signed({1'b0, r_focal}));
            end
            r38_az  <= r37_a[2];
            r38_bz  <= r37_b[2];
            r38_vis <= r37_vis;
        end
    end

    // ---------------- S39: magnitude, overflow screen ----------------
    // A quotient of 2^17 or more saturates any screen value, so it is
    // flagged here and the divider only resolves 17 bits.
    logic [PW-2:0]   w_pmag [NPROJ];
    logic [VW-1:0]   w_pz   [NPROJ];
    logic [NPROJ-1:0] w_ovf;
    logic [PW-1:0]   r39_num [NPROJ];
    logic [VW-1:0]   r39_den [NPROJ];
    t_proj_side      r39_side;

    always_comb begin
        for (int i = 0; i < NPROJ; i++) begin
            w_pmag[i] = r38_p[i][PW-1] ? (PW-1)'(-r38_p[i]) : (PW-1)'(r38_p[i]);
            w_pz[i]   = (i < 2) ? r38_az : r38_bz;
            w_ovf[i]  = {1'b0, w_pmag[i]} >= {w_pz[i], PROJ_QW'(0)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < NPROJ; i++) begin
                r39_num[i]      <= w_ovf[i] ? '0 : PW'(w_pmag[i]);
                r39_den[i]      <= w_pz[i];
                r39_side.neg[i] <= r38_p[i][PW-1];
            end
            r39_side.ovf <= w_ovf;
            r39_side.vis <= r38_vis;
        end
    end

    // ---------------- projection dividers (PROJ_QW stages) ----------------
    logic signed [PROJ_QW:0] w_pq [NPROJ];
    t_proj_side              r_pside [PROJ_QW];

    for (genvar i = 0; i < NPROJ; i++) begin : g_pdiv
        sncp_div #(.DW(VW), .QW(PROJ_QW)) u_div_p (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r39_num[i]),
            .i_den (r39_den[i]),
            .i_neg (r39_side.neg[i]),
            .o_quo (w_pq[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pside[0] <= r39_side;
            for (int i = 1; i < PROJ_QW; i++) begin
                r_pside[i] <= r_pside[i-1];
            end
        end
    end

    // ---------------- S57: center offset, saturate, output register ----------------
    localparam logic signed [PROJ_QW:0] QMAX = {1'b0, {PROJ_QW{1'b1}}};

    t_proj_side              w_ps;
    logic signed [PROJ_QW:0] w_q [NPROJ];
    logic signed [18:0]      w_sc [NPROJ];
    logic                    r_vis;
    logic [15:0]             r_scr [NPROJ];

    always_comb begin
        w_ps = r_pside[PROJ_QW-1];
        for (int i = 0; i < NPROJ; i++) begin
            if (w_ps.ovf[i]) w_q[i] = w_ps.neg[i] ? -QMAX : QMAX;
            else             w_q[i] = w_pq[i];
            // odd lanes are y: screen y points downward
            if (i % 2 == 0) w_sc[i] = 19'($signed(r_cx)) + 19'(w_q[i]);
            else            w_sc[i] = 19'($signed(r_cy)) - 19'(w_q[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_vis <= w_ps.vis;
            for (int i = 0; i < NPROJ; i++) begin
                r_scr[i] <= w_ps.vis ? sat16(w_sc[i]) : 16'h0000;
            end
        end
    end

    assign o_visible        = r_vis;
    assign o_start_screen_x = r_scr[0];
    assign o_start_screen_y = r_scr[1];
    assign o_end_screen_x   = r_scr[2];
    assign o_end_screen_y   = r_scr[3];

    // ---------------- assertions ----------------
    // invisible segments report zero coordinates
    a_invis_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_visible) |-> (o_start_screen_x == 16'sd0 &&
            o_start_screen_y == 16'sd0 && o_end_screen_x == 16'sd0 &&
            o_end_screen_y == 16'sd0))
        else $error("invisible word with nonzero coordinates");

    // a stalled output word freezes the input side
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while output stalled");

    // an empty output register never blocks the input
    a_free_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output register");

    // a word accepted while the pipe advances leaves stage one valid
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[1])
        else $error("accepted word lost at pipe entry");

endmodule
